### design/tns_pkg.sv
// Shared types and constants for the ticks-to-nanoseconds converter.
// No dependencies.
`default_nettype none
package tns_pkg;

    localparam int DATA_W    = 64;
    localparam int MULT_W    = 32;
    localparam int SHIFT_W   = 6;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int NUM_CELLS = DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MULT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHIFT = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] NS_FLOOR = DATA_W'(1000);

    typedef struct packed {
        logic              valid;
        logic [MULT_W-1:0] rem;
        logic [DATA_W-1:0] dq;
        logic [MULT_W-1:0] divisor;
    } t_div_beat;

endpackage
`default_nettype wire

### design/tns_front.sv
// Front end: scale with saturation, then optional round-up add.
// Depends on tns_pkg.
`default_nettype none
module tns_front
    import tns_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [DATA_W-1:0]  i_ticks,
    input  wire logic               i_is_max,
    input  wire logic [MULT_W-1:0]  i_multiplier,
    input  wire logic [SHIFT_W-1:0] i_shift,
    output t_div_beat               o_beat
);

    logic              r_valid_a;
    logic [DATA_W-1:0] r_scaled;
    logic [MULT_W-1:0] r_mult;
    logic              r_max_ok;
    t_div_beat         r_beat;

    logic [DATA_W-1:0] n_scaled;
    logic [MULT_W-1:0] n_mult;
    logic              n_max_ok;
    logic [DATA_W-1:0] rnd;
    logic [DATA_W-1:0] sum;

    always_comb begin
        if (|(i_ticks & ~(ALL_ONES >> i_shift))) begin
            n_scaled = ALL_ONES;
        end else begin
            n_scaled = i_ticks << i_shift;
        end
        n_mult   = (i_multiplier == '0) ? MULT_W'(1) : i_multiplier;
        n_max_ok = !i_is_max ||
                   ({{(DATA_W-MULT_W){1'b0}}, n_mult} <= (DATA_W'(1) << i_shift));
    end

    assign rnd = {{(DATA_W-MULT_W){1'b0}}, r_mult - MULT_W'(1)};

    always_comb begin
        if ((~r_scaled > rnd) && r_max_ok) begin
            sum = r_scaled + rnd;
        end else begin
            sum = r_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a    <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_valid_a    <= i_valid;
            r_beat.valid <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled       <= n_scaled;
            r_mult         <= n_mult;
            r_max_ok       <= n_max_ok;
            r_beat.rem     <= '0;
            r_beat.dq      <= sum;
            r_beat.divisor <= r_mult;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire

### design/tns_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on tns_pkg.
`default_nettype none
module tns_cell
    import tns_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_div_beat i_beat,
    output t_div_beat      o_beat
);

    t_div_beat         r_beat;
    logic [MULT_W:0]   trial;
    logic [MULT_W+1:0] diff;
    logic              ge;

    assign trial = {i_beat.rem, i_beat.dq[DATA_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, i_beat.divisor};
    assign ge    = !diff[MULT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.rem     <= ge ? diff[MULT_W-1:0] : trial[MULT_W-1:0];
            r_beat.dq      <= {i_beat.dq[DATA_W-2:0], ge};
            r_beat.divisor <= i_beat.divisor;
        end
    end

    assign o_beat = r_beat;

endmodule
`default_nettype wire

### design/ticks_to_ns_converter.sv
// Top level: config registers, front end, divider cell row, output floor.
// Depends on tns_pkg, tns_front, tns_cell.
`default_nettype none
// Converts ticks to ns as ceil((ticks << shift) / multiplier), floored at
// 1000 ns. One beat is accepted per cycle unless stalled; each result
// passes through two front-end stages (scale/saturate, round-up), a row
// of 64 division cells with one cell per quotient bit, and one output
// stage. The whole pipeline holds while a result waits under stall. Write
// configuration only while no conversion is in flight.
module ticks_to_ns_converter
    import tns_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [DATA_W-1:0]    i_ticks,
    input  wire logic                 i_is_max,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [DATA_W-1:0]         o_nanoseconds,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [MULT_W-1:0]  r_multiplier;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_ns;
    logic               en;
    logic [DATA_W-1:0]  quot;

    t_div_beat chain [NUM_CELLS+1];

    assign en          = !(r_out_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiplier <= MULT_W'(1);
            r_shift      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_MULT:  r_multiplier <= i_cfg_data[MULT_W-1:0];
                CFG_IDX_SHIFT: r_shift      <= i_cfg_data[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    tns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_ticks      (i_ticks),
        .i_is_max     (i_is_max),
        .i_multiplier (r_multiplier),
        .i_shift      (r_shift),
        .o_beat       (chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tns_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (chain[g]),
            .o_beat  (chain[g+1])
        );
    end

    assign quot = chain[NUM_CELLS].dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ns <= (quot > NS_FLOOR) ? quot : NS_FLOOR;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_nanoseconds = r_out_ns;

endmodule
`default_nettype wire

### bench/ticks_to_ns_converter_test.sv
// Testbench for ticks_to_ns_converter: a directed table, then random conversions under
// several register settings and idle patterns, checked against a local predictor
// (or the table's own value where given). Depends on tns_pkg and the converter RTL.
`timescale 1ns / 1ps

module ticks_to_ns_converter_test
    import tns_pkg::*;
;

    localparam logic [63:0] WIDE_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FLOOR_NS    = 64'd1000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAD = CFG_IDX_W'(8'hFF);
    localparam int          STALL_LIMIT = 20000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 80;
    localparam int          NUM_PHASES  = 12;
    localparam int          PHASE_BEATS = 100;
    localparam int          PLAN_LEN    = 26;

    typedef enum logic { ROW_BEAT, ROW_REG } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DAT_W-1:0]  data;
        logic [63:0]           ticks;
        logic                  is_max;
        logic                  typed;
        logic [63:0]           ns;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [DATA_W-1:0]    i_ticks;
    logic                 i_is_max;
    logic                 o_valid;
    logic                 i_stall;
    logic [DATA_W-1:0]    o_nanoseconds;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    ticks_to_ns_converter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ticks       (i_ticks),
        .i_is_max      (i_is_max),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_nanoseconds (o_nanoseconds),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    logic [63:0] ns_due[$];
    logic [31:0] mdl_mult;
    logic [5:0]  mdl_shift;
    int          fail_count;
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    bit          hold_done;
    int          quiet_cycles = 0;
    t_plan_row   plan [PLAN_LEN];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] predict_ns(logic [63:0] ticks, logic is_max,
                                               logic [31:0] mult, logic [5:0] shift);
        logic [63:0] m;
        logic [63:0] rnd;
        logic [63:0] scaled;
        logic [63:0] q;
        m      = (mult == 32'd0) ? 64'd1 : {32'd0, mult};
        rnd    = m - 64'd1;
        scaled = ticks << shift;
        if ((scaled >> shift) != ticks)
            scaled = WIDE_ONES;
        if (((WIDE_ONES - scaled) > rnd) && (!is_max || m <= (64'd1 << shift)))
            scaled = scaled + rnd;
        q = scaled / m;
        return (q > FLOOR_NS) ? q : FLOOR_NS;
    endfunction

    function automatic logic [63:0] pick_ticks(logic [31:0] mult);
        logic [63:0] q;
        case ($urandom_range(5))
            0: pick_ticks = {$urandom, $urandom};
            1: pick_ticks = 64'($urandom_range(5000));
            2: pick_ticks = WIDE_ONES - 64'($urandom_range(50));
            3: pick_ticks = {$urandom, $urandom} >> $urandom_range(63);
            4: begin
                q = {$urandom, $urandom} >> $urandom_range(63, 32);
                pick_ticks = {32'd0, mult} * q + 64'($urandom_range(2)) - 64'd1;
            end
            default: pick_ticks = 64'd1 << $urandom_range(63);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(logic [63:0] ticks, logic is_max, logic typed, logic [63:0] ns);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_ticks  <= ticks;
        i_is_max <= is_max;
        do @(posedge i_clk); while (o_stall);
        ns_due.push_back(typed ? ns : predict_ns(ticks, is_max, mdl_mult, mdl_shift));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IDX_MULT)
            mdl_mult = data;
        else if (idx == CFG_IDX_SHIFT)
            mdl_shift = data[5:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (ns_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        i_stall   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (ns_due.size() == 0) begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("unexpected beat: nanoseconds %h", o_nanoseconds);
                mismatch_count++;
            end else begin
                want = ns_due.pop_front();
                if (o_nanoseconds !== want) begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("nanoseconds mismatch: expected %h actual %h",
                                 want, o_nanoseconds);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int p;
        logic [31:0] mult;
        logic [5:0]  shift;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ticks        = '0;
        i_is_max       = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        fail_count     = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        mdl_mult       = 32'd1;
        mdl_shift      = 6'd0;

        plan = '{
            '{ROW_BEAT, '0, '0, 64'd0, 1'b0, 1'b1, FLOOR_NS},
            '{ROW_BEAT, '0, '0, WIDE_ONES, 1'b0, 1'b1, WIDE_ONES},
            '{ROW_BEAT, '0, '0, WIDE_ONES, 1'b1, 1'b1, WIDE_ONES},
            '{ROW_BEAT, '0, '0, 64'd1000, 1'b0, 1'b1, FLOOR_NS},
            '{ROW_BEAT, '0, '0, 64'd1001, 1'b1, 1'b1, 64'd1001},
            '{ROW_REG, CFG_IDX_MULT, 32'd0, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'd12345, 1'b0, 1'b1, 64'd12345},
            '{ROW_REG, CFG_IDX_SHIFT, 32'd63, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'd1, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'd3, 1'b1, 1'b1, WIDE_ONES},
            '{ROW_REG, CFG_IDX_MULT, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, CFG_IDX_SHIFT, 32'd32, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, WIDE_ONES, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'hFFFF_FFFF, 1'b1, 1'b0, '0},
            '{ROW_REG, CFG_IDX_SHIFT, 32'd0, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'h4_FFFF_FFFC, 1'b1, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'h4_FFFF_FFFC, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'd7, 1'b0, 1'b1, FLOOR_NS},
            '{ROW_REG, CFG_IDX_BAD, 32'hDEAD_BEEF, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'h4_FFFF_FFFC, 1'b0, 1'b0, '0},
            '{ROW_REG, CFG_IDX_MULT, 32'd3, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, CFG_IDX_SHIFT, 32'hFFFF_FFC1, '0, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, WIDE_ONES, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, WIDE_ONES >> 1, 1'b0, 1'b0, '0},
            '{ROW_BEAT, '0, '0, 64'd2999, 1'b1, 1'b0, '0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_REG) begin
                i_valid <= 1'b0;
                wait_drained();
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                send_beat(plan[r].ticks, plan[r].is_max, plan[r].typed, plan[r].ns);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            i_valid <= 1'b0;
            wait_drained();
            case (p)
                0: begin mult = 32'd1;        shift = 6'd0;  end
                1: begin mult = 32'hFFFF_FFFF; shift = 6'd32; end
                2: begin mult = 32'd0;        shift = 6'd63; end
                3: begin mult = 32'hFFFF_FFFF; shift = 6'd0;  end
                default: begin
                    case ($urandom_range(3))
                        0: mult = $urandom;
                        1: mult = $urandom_range(1000, 1);
                        2: mult = 32'd1 << $urandom_range(31);
                        default: mult = $urandom_range(1);
                    endcase
                    shift = ($urandom_range(3) == 0) ? 6'($urandom_range(63, 33))
                                                     : 6'($urandom_range(32));
                end
            endcase
            write_reg(CFG_IDX_MULT, mult);
            write_reg(CFG_IDX_SHIFT, ($urandom & 32'hFFFF_FFC0) | {26'd0, shift});
            write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (p == 4) begin
                send_idle_pct = 0;
                hold_req      = 1'b1;
            end
            repeat (PHASE_BEATS) send_beat(pick_ticks(mdl_mult), 1'($urandom_range(1)), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (ns_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && ns_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
